@@ design/pmgr_pkg.sv @@
// Shared types, constants and CRC helper for the packet-mode group reassembler.
package pmgr_pkg;

   localparam int FBL_W       = 13;  // frame byte counter width
   localparam int POS_W       = 7;   // byte position inside a packet
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   localparam logic [15:0] CRC_PRESET   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [15:0] CRC_RESIDUE  = 16'h1D0F;
   localparam logic [10:0] RATE_RESET   = 11'd8;

   // register indexes of the configuration port
   localparam logic [0:0] CSR_PACKET_ADDRESS = 1'b0;
   localparam logic [0:0] CSR_BIT_RATE       = 1'b1;

   // first/last flag codes of the packet header
   localparam logic [1:0] FL_MIDDLE = 2'b00;
   localparam logic [1:0] FL_LAST   = 2'b01;
   localparam logic [1:0] FL_FIRST  = 2'b10;
   localparam logic [1:0] FL_SINGLE = 2'b11;

   typedef enum logic [2:0] {
      KIND_PAYLOAD   = 3'd0,
      KIND_CRC_FAIL  = 3'd1,
      KIND_DROPPED   = 3'd2,
      KIND_STARTED   = 3'd3,
      KIND_CONTINUED = 3'd4,
      KIND_COMPLETED = 3'd5,
      KIND_SINGLE    = 3'd6,
      KIND_ABORTED   = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_VERDICT = 2'd1,
      EV_ABORT   = 2'd2
   } ev_code_type;

   // one classified event handed from front to back
   typedef struct packed {
      ev_code_type code;
      logic        crc_ok;
      logic [1:0]  flags;
      logic [7:0]  data;
   } evt_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // packet length in bytes from the two-bit length code
   function automatic logic [POS_W-1:0] pkt_len(input logic [1:0] code);
      logic [POS_W-1:0] l;
      case (code)
         2'd0: l = 7'd24;
         2'd1: l = 7'd48;
         2'd2: l = 7'd72;
         2'd3: l = 7'd96;
         default: l = 7'd24;
      endcase
      return l;
   endfunction

endpackage

@@ design/packet_mode_group_reassembler_top.sv @@
// Top level of the packet-mode data group reassembler.
// Takes one sub-channel frame byte per word on req_ and gives payload bytes and
// per-packet verdicts on rsp_. Throughput is one byte per clock while the queue
// is not full: the front end handles framing, header parse, address and
// continuity check and the CRC-16 update for each byte as it is accepted, then
// hands at most one classified event per byte into a four-word queue. The back
// end tracks the group state and registers the result word; each result passes
// through the queue and then the output register. req_tready falls only while
// the queue is full, i.e. while rsp_ is back-pressured. A frame is 3 * bit rate
// bytes, capped at MAX_FRAME_BYTES, latched at each frame_start; bit-rate writes
// apply from the next frame, the address at once. No clearing pass after reset.
module packet_mode_group_reassembler_top import pmgr_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 5472
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] frame_start
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] value
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   // configuration: 0 packet_address, 1 bit_rate_kbps
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   logic    evt_valid, q_full, q_empty, q_pop;
   evt_type evt, q_head;

   // classify each byte; stalls only on a full queue
   pmgr_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .evt_valid  (evt_valid),
      .evt        (evt)
   );

   pmgr_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (evt_valid),
      .push_evt (evt),
      .pop      (q_pop),
      .empty    (q_empty),
      .full     (q_full),
      .head     (q_head)
   );

   // group state and output register
   pmgr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ design/pmgr_front.sv @@
// Front end: framing, header parse, address/continuity filter, CRC, event classification.
module pmgr_front import pmgr_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 5472
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        q_full,
   output logic        evt_valid,
   output evt_type     evt
);

   localparam logic [FBL_W-1:0] MAX_LEN = FBL_W'(MAX_FRAME_BYTES);

   logic [9:0]       addr_ff, addr_in;
   logic [10:0]      rate_ff, rate_in;
   logic [FBL_W-1:0] fbl_ff, fbl_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] plen_ff, plen_in;
   logic [7:0]       hdr0_ff, hdr0_in;
   logic [6:0]       useful_ff, useful_in;
   logic [15:0]      crc_ff, crc_in;
   logic [1:0]       exp_ff, exp_in;
   logic             acc_ff, acc_in;
   logic             aband_ff, aband_in;

   logic [FBL_W-1:0] three_rate, frame_len, fbl_e;
   logic [POS_W-1:0] pos_e, plen_c, plen_cur, room, useful_lim;
   logic             acc_e, aband_e, abort_e, acc_cur, fire, start, active, short_c, last_c;
   logic [15:0]      crc_new;
   logic [7:0]       b;
   logic             ev_valid_c;
   evt_type          evt_c;

   assign b     = req_tdata;
   assign start = req_tuser[0];
   assign req_tready = !q_full;
   assign fire  = req_tvalid && !q_full;

   assign three_rate = {1'b0, rate_ff, 1'b0} + {2'b00, rate_ff};
   assign frame_len  = (three_rate > MAX_LEN) ? MAX_LEN : three_rate;

   // frame_start restarts the framing before the byte is looked at
   assign fbl_e   = start ? frame_len : fbl_ff;
   assign pos_e   = start ? '0 : pos_ff;
   assign acc_e   = start ? 1'b0 : acc_ff;
   assign aband_e = start ? 1'b0 : aband_ff;
   assign abort_e = start && (pos_ff != '0) && acc_ff;

   assign active  = (fbl_e != '0) && !aband_e;
   assign plen_c  = pkt_len(b[7:6]);
   assign short_c = (pos_e == '0) && (fbl_e < {6'd0, plen_c});
   assign plen_cur = (pos_e == '0) ? plen_c : plen_ff;
   assign crc_new = crc_feed((pos_e == '0) ? CRC_PRESET : crc_ff, b);
   assign room       = plen_ff - 7'd5;
   assign useful_lim = (useful_ff > room) ? room : useful_ff;
   assign last_c  = ({1'b0, pos_e} + 8'd1) >= {1'b0, plen_cur};

   always_comb begin
      addr_in   = addr_ff;
      rate_in   = rate_ff;
      fbl_in    = fbl_ff;
      pos_in    = pos_ff;
      plen_in   = plen_ff;
      hdr0_in   = hdr0_ff;
      useful_in = useful_ff;
      crc_in    = crc_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      aband_in  = aband_ff;
      acc_cur   = acc_e;
      ev_valid_c = 1'b0;
      evt_c      = '{code: EV_PAYLOAD, crc_ok: 1'b0, flags: 2'b00, data: 8'h00};

      if (csr_wr_en) begin
         case (csr_index)
            CSR_PACKET_ADDRESS: addr_in = csr_wdata[9:0];
            CSR_BIT_RATE: rate_in = csr_wdata;
            default: ;
         endcase
      end

      if (pos_e == '0) begin
         acc_cur = 1'b0;
      end else if (pos_e == 7'd1) begin
         if ({hdr0_ff[1:0], b} == addr_ff && hdr0_ff[5:4] == exp_ff) acc_cur = 1'b1;
      end

      if (fire) begin
         fbl_in   = fbl_e;
         pos_in   = pos_e;
         acc_in   = acc_e;
         aband_in = aband_e;
         if (abort_e) begin
            ev_valid_c = 1'b1;
            evt_c.code = EV_ABORT;
         end
         if (active && short_c) begin
            aband_in = 1'b1;
         end else if (active) begin
            if (pos_e == '0) begin
               plen_in = plen_c;
               hdr0_in = b;
            end else if (pos_e == 7'd1) begin
               if ({hdr0_ff[1:0], b} == addr_ff) begin
                  if (hdr0_ff[5:4] != exp_ff) exp_in = 2'd0;
                  else exp_in = exp_ff + 2'd1;
               end
            end else if (pos_e == 7'd2) begin
               useful_in = b[6:0];
            end else if ((({1'b0, pos_e} + 8'd2) < {1'b0, plen_ff}) && acc_e
                         && ((pos_e - 7'd3) < useful_lim)) begin
               ev_valid_c = 1'b1;
               evt_c.code = EV_PAYLOAD;
               evt_c.data = b;
            end
            crc_in = crc_new;
            fbl_in = fbl_e - 13'd1;
            if (last_c) begin
               if (acc_cur) begin
                  ev_valid_c   = 1'b1;
                  evt_c.code   = EV_VERDICT;
                  evt_c.crc_ok = (crc_new == CRC_RESIDUE);
                  evt_c.flags  = hdr0_ff[3:2];
               end
               pos_in = '0;
               acc_in = 1'b0;
            end else begin
               pos_in = pos_e + 7'd1;
               acc_in = acc_cur;
            end
         end
      end
   end

   assign evt_valid = fire && ev_valid_c;
   assign evt       = evt_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         rate_ff   <= RATE_RESET;
         fbl_ff    <= '0;
         pos_ff    <= '0;
         plen_ff   <= '0;
         hdr0_ff   <= '0;
         useful_ff <= '0;
         crc_ff    <= CRC_PRESET;
         exp_ff    <= '0;
         acc_ff    <= 1'b0;
         aband_ff  <= 1'b0;
      end else begin
         addr_ff   <= addr_in;
         rate_ff   <= rate_in;
         fbl_ff    <= fbl_in;
         pos_ff    <= pos_in;
         plen_ff   <= plen_in;
         hdr0_ff   <= hdr0_in;
         useful_ff <= useful_in;
         crc_ff    <= crc_in;
         exp_ff    <= exp_in;
         acc_ff    <= acc_in;
         aband_ff  <= aband_in;
      end
   end

endmodule

@@ design/pmgr_fifo.sv @@
// Short event queue between front end and back end.
module pmgr_fifo import pmgr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  evt_type push_evt,
   input  logic    pop,
   output logic    empty,
   output logic    full,
   output evt_type head
);

   evt_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_CW-1:0]   cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + QUEUE_AW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QUEUE_AW'(1) : rd_ff;
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10: cnt_in = cnt_ff + QUEUE_CW'(1);
         2'b01: cnt_in = cnt_ff - QUEUE_CW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_evt;
   end

endmodule

@@ design/pmgr_back.sv @@
// Back end: group state tracking, verdict kind and the registered result word.
module pmgr_back import pmgr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  evt_type    q_head,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [2:0] rsp_tuser
);

   logic       in_group_ff, in_group_in;
   logic       valid_ff, valid_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] value_ff, value_in;

   assign q_pop = !q_empty && (!valid_ff || rsp_tready);

   always_comb begin
      in_group_in = in_group_ff;
      valid_in    = valid_ff && !rsp_tready;
      kind_in     = kind_ff;
      value_in    = value_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         value_in = 8'h00;
         case (q_head.code)
            EV_PAYLOAD: begin
               kind_in  = KIND_PAYLOAD;
               value_in = q_head.data;
            end
            EV_ABORT: begin
               kind_in     = KIND_ABORTED;
               in_group_in = 1'b0;
            end
            EV_VERDICT: begin
               if (!q_head.crc_ok) begin
                  kind_in = KIND_CRC_FAIL;
               end else if (!in_group_ff) begin
                  case (q_head.flags)
                     FL_FIRST: begin
                        kind_in     = KIND_STARTED;
                        in_group_in = 1'b1;
                     end
                     FL_SINGLE: kind_in = KIND_SINGLE;
                     default: kind_in = KIND_DROPPED;
                  endcase
               end else begin
                  case (q_head.flags)
                     FL_MIDDLE: kind_in = KIND_CONTINUED;
                     FL_LAST: begin
                        kind_in     = KIND_COMPLETED;
                        in_group_in = 1'b0;
                     end
                     FL_FIRST: kind_in = KIND_STARTED;
                     default: begin
                        kind_in     = KIND_ABORTED;
                        in_group_in = 1'b0;
                     end
                  endcase
               end
            end
            default: kind_in = KIND_PAYLOAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_group_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         in_group_ff <= in_group_in;
         valid_ff    <= valid_in;
      end
      kind_ff  <= kind_in;
      value_ff <= value_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = kind_ff;

endmodule
